// ===== sv/scfh_pkg.sv =====
// ----------------------------------------------------------------------------
// scfh_pkg: shared types, constants and helpers for the command frame handler
// Frame layout, command codes, the frame check byte and the small structs
// that pass between the parser and the transmit queue.
// ----------------------------------------------------------------------------
package scfh_pkg;

   // Frame geometry and field widths
   localparam int FRAME_LEN         = 9;
   localparam int BYTE_W            = 8;
   localparam int WORD_W            = 16;
   localparam int SERIAL_W          = 40;
   localparam int CNT_W             = 4;
   localparam int FRAME_QUEUE_DEPTH = 2;

   // Request kinds
   localparam logic REQ_RX_BYTE = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   // Header and upload frame bytes
   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] ADDR_BYTE   = 8'h01;
   localparam logic [7:0] MODE_UPLOAD = 8'h40;
   localparam logic [7:0] UPLOAD_CODE = 8'h17;
   localparam logic [7:0] UPLOAD_B2   = 8'h04;
   localparam logic [7:0] UPLOAD_B6   = 8'h13;
   localparam logic [7:0] UPLOAD_B7   = 8'h88;

   // Command codes
   localparam logic [7:0] CMD_SET_SERIAL  = 8'h31;
   localparam logic [7:0] CMD_GET_SERIAL  = 8'h32;
   localparam logic [7:0] CMD_GET_CAL_PPB = 8'h34;
   localparam logic [7:0] CMD_GET_CAL_RAW = 8'h35;
   localparam logic [7:0] CMD_ECHO_A      = 8'h36;
   localparam logic [7:0] CMD_ECHO_B      = 8'h37;
   localparam logic [7:0] CMD_SET_ZERO    = 8'h38;
   localparam logic [7:0] CMD_SET_SPAN    = 8'h39;
   localparam logic [7:0] CMD_SET_MODE_A  = 8'h78;
   localparam logic [7:0] CMD_SET_MODE_B  = 8'h3A;
   localparam logic [7:0] CMD_READ_ALL    = 8'h86;
   localparam logic [7:0] CMD_READ_RAW    = 8'h87;

   // One whole frame, byte 0 first
   typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_type;

   // Parser to queue: a finished frame to send
   typedef struct packed {
      logic      valid;
      frame_type data;
   } frame_emit_type;

   // Queue to parser: back pressure
   typedef struct packed {
      logic full;
   } queue_status_type;

   // True for the codes the handler executes
   function automatic logic is_valid_code(input logic [7:0] b);
      logic ok;
      case (b)
         CMD_SET_SERIAL, CMD_GET_SERIAL, CMD_GET_CAL_PPB, CMD_GET_CAL_RAW,
         CMD_ECHO_A, CMD_ECHO_B, CMD_SET_ZERO, CMD_SET_SPAN,
         CMD_SET_MODE_A, CMD_SET_MODE_B, CMD_READ_ALL, CMD_READ_RAW: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // Two's complement of the 8-bit sum of bytes 1..7
   function automatic logic [7:0] frame_check(input frame_type f);
      logic [7:0] s;
      s = '0;
      for (int i = 1; i <= 7; i++) begin
         s = s + f[i];
      end
      return 8'(8'h00 - s);
   endfunction

endpackage

// ===== sv/scfh_if.sv =====
// ----------------------------------------------------------------------------
// scfh_if: valid/ready channels of the command frame handler
// Request channel (received byte or upload tick) and response channel
// (one transmitted byte per beat).
// ----------------------------------------------------------------------------
interface scfh_req_if;
   import scfh_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BYTE_W-1:0] rx_byte;
   logic [WORD_W-1:0] adc_sample;
   logic [WORD_W-1:0] ppb_value;

   modport source (output valid, req_type, rx_byte, adc_sample, ppb_value,
                   input ready);
   modport sink   (input valid, req_type, rx_byte, adc_sample, ppb_value,
                   output ready);
endinterface

interface scfh_rsp_if;
   import scfh_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] tx_byte;
   logic              frame_last;

   modport source (output valid, tx_byte, frame_last, input ready);
   modport sink   (input valid, tx_byte, frame_last, output ready);
endinterface

// ===== sv/sensor_command_frame_handler.sv =====
// ----------------------------------------------------------------------------
// sensor_command_frame_handler: 9-byte command frame handler for a gas sensor
// Parses FF 01 command frames from received bytes, executes them, and sends
// 9-byte replies or the periodic upload frame.
// ----------------------------------------------------------------------------
// One request (a received byte or an upload tick) is taken per clock. Each
// request passes through an input register and one pass of parse/execute
// logic, whose frame (if any) lands in a frame queue of QUEUE_DEPTH entries.
// Each queued frame leaves as nine response beats, one per cycle while the
// receiver is ready, frame_last on the ninth. Requests flow one per cycle
// while the queue has room; when frames come faster than the response side
// drains them, the drain rate sets the request rate. An accepted byte passes
// the input register, a queue entry and the output frame register in turn.
module sensor_command_frame_handler #(
   parameter int QUEUE_DEPTH = scfh_pkg::FRAME_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   scfh_req_if.sink    req_bus,
   scfh_rsp_if.source  rsp_bus
);
   import scfh_pkg::*;

   frame_emit_type   emit;
   queue_status_type queue_status;

   // Frame parser and command execution
   scfh_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .queue_status (queue_status),
      .emit         (emit)
   );

   // Frame queue and byte serializer
   scfh_tx #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_tx (
      .clock        (clock),
      .reset        (reset),
      .emit         (emit),
      .queue_status (queue_status),
      .rsp_bus      (rsp_bus)
   );

endmodule

// ===== sv/scfh_parser.sv =====
// ----------------------------------------------------------------------------
// scfh_parser: frame assembly and command execution
// Input register, then one pass of logic that assembles the 9-byte command
// frame, checks it, runs the command and builds the reply or upload frame.
// ----------------------------------------------------------------------------
module scfh_parser (
   input  logic                      clock,
   input  logic                      reset,
   scfh_req_if.sink                  req_bus,
   input  scfh_pkg::queue_status_type queue_status,
   output scfh_pkg::frame_emit_type   emit
);
   import scfh_pkg::*;

   // Input register
   logic              stage_valid_ff, stage_valid_in;
   logic              stage_type_ff;
   logic [BYTE_W-1:0] stage_byte_ff;
   logic [WORD_W-1:0] stage_adc_ff;
   logic [WORD_W-1:0] stage_ppb_ff;

   // Assembly and device state
   logic [CNT_W-1:0]    rx_count_ff, rx_count_in;
   frame_type           frame_ff, frame_in;
   logic [BYTE_W-1:0]   last1_ff, last1_in;
   logic [BYTE_W-1:0]   last2_ff, last2_in;
   logic [WORD_W-1:0]   zero_ppb_ff, zero_ppb_in;
   logic [WORD_W-1:0]   span_ppb_ff, span_ppb_in;
   logic [WORD_W-1:0]   zero_sample_ff, zero_sample_in;
   logic [WORD_W-1:0]   span_sample_ff, span_sample_in;
   logic [BYTE_W-1:0]   mode_ff, mode_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;

   logic      fire;
   logic      accept;
   logic      emit_valid;
   frame_type full_frame;
   frame_type reply;
   logic [BYTE_W-1:0] code;

   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

   // Stage advances whenever the queue has room for a frame
   assign fire          = stage_valid_ff && !queue_status.full;
   assign req_bus.ready = !stage_valid_ff || !queue_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign stage_valid_in = req_bus.ready ? req_bus.valid : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_type_ff <= req_bus.req_type;
         stage_byte_ff <= req_bus.rx_byte;
         stage_adc_ff  <= req_bus.adc_sample;
         stage_ppb_ff  <= req_bus.ppb_value;
      end
   end

   // Completed frame as it stands with the new byte in the check position
   always_comb begin
      full_frame    = frame_ff;
      full_frame[8] = stage_byte_ff;
   end

   assign code = frame_ff[2];

   // Assembly, execution and reply build
   always_comb begin
      rx_count_in    = rx_count_ff;
      frame_in       = frame_ff;
      last1_in       = last1_ff;
      last2_in       = last2_ff;
      zero_ppb_in    = zero_ppb_ff;
      span_ppb_in    = span_ppb_ff;
      zero_sample_in = zero_sample_ff;
      span_sample_in = span_sample_ff;
      mode_in        = mode_ff;
      serial_in      = serial_ff;
      emit_valid     = 1'b0;
      reply          = '0;

      if (fire) begin
         if (stage_type_ff == REQ_TICK) begin
            // periodic upload frame
            if (mode_ff == MODE_UPLOAD) begin
               emit_valid = 1'b1;
               reply[0]   = SYNC_BYTE;
               reply[1]   = UPLOAD_CODE;
               reply[2]   = UPLOAD_B2;
               reply[3]   = 8'h00;
               reply[4]   = stage_ppb_ff[15:8];
               reply[5]   = stage_ppb_ff[7:0];
               reply[6]   = UPLOAD_B6;
               reply[7]   = UPLOAD_B7;
            end
         end else begin
            // last two bytes held, for the header-seen-again test
            last2_in = last1_ff;
            last1_in = stage_byte_ff;
            case (rx_count_ff)
               4'd0: begin
                  if (stage_byte_ff == SYNC_BYTE) begin
                     frame_in[0] = SYNC_BYTE;
                     rx_count_in = 4'd1;
                  end
               end
               4'd1: begin
                  if (stage_byte_ff == ADDR_BYTE) begin
                     frame_in[1] = ADDR_BYTE;
                     rx_count_in = 4'd2;
                  end else begin
                     rx_count_in = 4'd0;
                  end
               end
               4'd2: begin
                  if (is_valid_code(stage_byte_ff)) begin
                     frame_in[2] = stage_byte_ff;
                     rx_count_in = 4'd3;
                  end else begin
                     rx_count_in = 4'd0;
                  end
               end
               default: begin
                  if (last2_ff == SYNC_BYTE && last1_ff == ADDR_BYTE &&
                      is_valid_code(stage_byte_ff)) begin
                     // header seen again: restart with this code
                     frame_in[2] = stage_byte_ff;
                     rx_count_in = 4'd3;
                  end else if (rx_count_ff != LAST_POS) begin
                     frame_in[rx_count_ff] = stage_byte_ff;
                     rx_count_in = rx_count_ff + 4'd1;
                  end else if (frame_check(full_frame) == stage_byte_ff) begin
                     // good frame: execute and reply
                     frame_in[8] = stage_byte_ff;
                     rx_count_in = 4'd0;
                     emit_valid  = 1'b1;
                     reply[0]    = SYNC_BYTE;
                     reply[1]    = code;
                     reply[2]    = code;
                     reply[7:3]  = frame_ff[7:3];
                     case (code)
                        CMD_SET_SERIAL: begin
                           serial_in  = {frame_ff[3], frame_ff[4], frame_ff[5],
                                         frame_ff[6], frame_ff[7]};
                           reply[2]   = frame_ff[3];
                           reply[3]   = frame_ff[4];
                           reply[4]   = frame_ff[5];
                           reply[5]   = frame_ff[6];
                           reply[6]   = frame_ff[7];
                           reply[7]   = 8'h00;
                        end
                        CMD_GET_SERIAL: begin
                           reply[2] = serial_ff[39:32];
                           reply[3] = serial_ff[31:24];
                           reply[4] = serial_ff[23:16];
                           reply[5] = serial_ff[15:8];
                           reply[6] = serial_ff[7:0];
                           reply[7] = 8'h00;
                        end
                        CMD_GET_CAL_PPB: begin
                           reply[2] = zero_ppb_ff[15:8];
                           reply[3] = zero_ppb_ff[7:0];
                           reply[4] = span_ppb_ff[15:8];
                           reply[5] = span_ppb_ff[7:0];
                           reply[6] = 8'h00;
                           reply[7] = 8'h00;
                        end
                        CMD_GET_CAL_RAW: begin
                           reply[2] = zero_sample_ff[15:8];
                           reply[3] = zero_sample_ff[7:0];
                           reply[4] = span_sample_ff[15:8];
                           reply[5] = span_sample_ff[7:0];
                           reply[6] = 8'h00;
                           reply[7] = 8'h00;
                        end
                        CMD_SET_ZERO: begin
                           zero_ppb_in    = {frame_ff[3], frame_ff[4]};
                           zero_sample_in = {frame_ff[5], frame_ff[6]};
                           reply[2]       = frame_ff[3];
                           reply[3]       = frame_ff[4];
                           reply[4]       = frame_ff[5];
                           reply[5]       = frame_ff[6];
                           reply[6]       = 8'h00;
                           reply[7]       = 8'h00;
                        end
                        CMD_SET_SPAN: begin
                           span_ppb_in    = {frame_ff[3], frame_ff[4]};
                           span_sample_in = {frame_ff[5], frame_ff[6]};
                           reply[2]       = frame_ff[3];
                           reply[3]       = frame_ff[4];
                           reply[4]       = frame_ff[5];
                           reply[5]       = frame_ff[6];
                           reply[6]       = 8'h00;
                           reply[7]       = 8'h00;
                        end
                        CMD_SET_MODE_A, CMD_SET_MODE_B: begin
                           mode_in    = frame_ff[3];
                           reply[2]   = frame_ff[3];
                           reply[7:3] = '0;
                        end
                        CMD_READ_ALL: begin
                           reply[2] = stage_adc_ff[15:8];
                           reply[3] = stage_adc_ff[7:0];
                           reply[4] = 8'h00;
                           reply[5] = 8'h00;
                           reply[6] = stage_ppb_ff[15:8];
                           reply[7] = stage_ppb_ff[7:0];
                        end
                        CMD_READ_RAW: begin
                           reply[2]   = stage_adc_ff[15:8];
                           reply[3]   = stage_adc_ff[7:0];
                           reply[7:4] = '0;
                        end
                        default: begin
                           // echo codes keep the received bytes
                        end
                     endcase
                  end else if (stage_byte_ff == SYNC_BYTE) begin
                     // bad check, tail holds a sync byte
                     frame_in[0] = SYNC_BYTE;
                     rx_count_in = 4'd1;
                  end else if (last1_ff == SYNC_BYTE &&
                               stage_byte_ff == ADDR_BYTE) begin
                     // bad check, tail holds a full header
                     frame_in[0] = SYNC_BYTE;
                     frame_in[1] = ADDR_BYTE;
                     rx_count_in = 4'd2;
                  end else begin
                     rx_count_in = 4'd0;
                  end
               end
            endcase
         end
      end
      reply[8] = frame_check(reply);
   end

   assign emit.valid = emit_valid;
   assign emit.data  = reply;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff    <= '0;
         frame_ff       <= '0;
         last1_ff       <= '0;
         last2_ff       <= '0;
         zero_ppb_ff    <= '0;
         span_ppb_ff    <= '0;
         zero_sample_ff <= '0;
         span_sample_ff <= '0;
         mode_ff        <= '0;
         serial_ff      <= '0;
      end else begin
         rx_count_ff    <= rx_count_in;
         frame_ff       <= frame_in;
         last1_ff       <= last1_in;
         last2_ff       <= last2_in;
         zero_ppb_ff    <= zero_ppb_in;
         span_ppb_ff    <= span_ppb_in;
         zero_sample_ff <= zero_sample_in;
         span_sample_ff <= span_sample_in;
         mode_ff        <= mode_in;
         serial_ff      <= serial_in;
      end
   end

   // Assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= LAST_POS)
      else $error("frame byte count out of range");

   a_emit_on_fire: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (stage_valid_ff && !queue_status.full))
      else $error("frame emitted without a stage advance");

   a_header_held: assert property (@(posedge clock) disable iff (reset)
      (rx_count_ff >= 4'd2) |-> (frame_ff[1] == ADDR_BYTE))
      else $error("assembly past header without address byte held");

endmodule

// ===== sv/scfh_tx.sv =====
// ----------------------------------------------------------------------------
// scfh_tx: frame queue and byte serializer
// Holds finished frames in a small queue and sends each one as nine beats,
// flagging the last byte. A frame already queued follows with no gap.
// ----------------------------------------------------------------------------
module scfh_tx #(
   parameter int QUEUE_DEPTH = scfh_pkg::FRAME_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  scfh_pkg::frame_emit_type    emit,
   output scfh_pkg::queue_status_type  queue_status,
   scfh_rsp_if.source                 rsp_bus
);
   import scfh_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] QCNT_MAX = QCNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(FRAME_LEN - 1);

   frame_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   frame_type          out_frame_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               busy_ff, busy_in;

   logic push, pop, take, last_take;

   // Handshake bookkeeping
   assign push      = emit.valid;
   assign take      = busy_ff && rsp_bus.ready;
   assign last_take = take && (idx_ff == LAST_IDX);
   assign pop       = (count_ff != '0) && (!busy_ff || last_take);

   assign queue_status.full = (count_ff == QCNT_MAX);

   // Pointer, count and serializer next state
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      idx_in    = idx_ff;
      busy_in   = busy_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         idx_in    = '0;
         busy_in   = 1'b1;
      end else if (take) begin
         idx_in = idx_ff + CNT_W'(1);
         if (last_take) begin
            busy_in = 1'b0;
         end
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         idx_ff    <= '0;
         busy_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         busy_ff   <= busy_in;
      end
   end

   // Frame storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= emit.data;
      end
      if (pop) begin
         out_frame_ff <= queue_ff[rd_ptr_ff];
      end
   end

   // Output beat
   assign rsp_bus.valid      = busy_ff;
   assign rsp_bus.tx_byte    = out_frame_ff[idx_ff];
   assign rsp_bus.frame_last = (idx_ff == LAST_IDX);

   // Assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_MAX)
      else $error("frame queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> !queue_status.full)
      else $error("frame pushed into full queue");

   a_idle_when_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(count_ff) == '0))
      else $error("serializer went idle with frames queued");

endmodule

// ===== verif/tb_sensor_command_frame_handler.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_command_frame_handler: self-checking bench for the frame handler
// Feeds received bytes and upload ticks through the request channel, keeps a
// shadow of the parser and the stored settings, and checks every reply beat
// (byte and last flag) against the frames that shadow predicts. Covers header
// search, header restart, bad checksum recovery, all command codes, upload
// ticks, then random well-formed and broken traffic with random idling.
// ----------------------------------------------------------------------------
module tb_sensor_command_frame_handler;
   import scfh_pkg::*;

   localparam int TOTAL_ITEMS   = 330;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 1000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } tx_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   scfh_req_if req_bus ();
   scfh_rsp_if rsp_bus ();

   sensor_command_frame_handler DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [7:0] command_codes [12] = '{
      CMD_SET_SERIAL, CMD_GET_SERIAL, CMD_GET_CAL_PPB, CMD_GET_CAL_RAW,
      CMD_ECHO_A, CMD_ECHO_B, CMD_SET_ZERO, CMD_SET_SPAN,
      CMD_SET_MODE_A, CMD_SET_MODE_B, CMD_READ_ALL, CMD_READ_RAW
   };

   // Shadow of the handler: assembly buffer and stored settings
   frame_type         held          = '0;
   logic [CNT_W-1:0]  held_count    = '0;
   logic [15:0]       zero_ppb_reg  = '0;
   logic [15:0]       span_ppb_reg  = '0;
   logic [15:0]       zero_raw_reg  = '0;
   logic [15:0]       span_raw_reg  = '0;
   logic [7:0]        mode_reg      = '0;
   logic [39:0]       serial_reg    = '0;

   tx_beat_type expected_tx [$];
   tx_beat_type want;

   int  fail_count   = 0;
   int  items_sent   = 0;
   int  ticks_sent   = 0;
   int  frames_seen  = 0;
   int  rsp_hold     = 0;
   bit  req_no_idle  = 1'b0;
   bit  rsp_no_idle  = 1'b0;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic bit code_is_known(input logic [7:0] b);
      bit hit;
      hit = 1'b0;
      foreach (command_codes[i]) begin
         if (command_codes[i] == b) hit = 1'b1;
      end
      return hit;
   endfunction

   // negated sum of bytes 1..7
   function automatic logic [7:0] sum_check(input frame_type f);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 1; i <= 7; i++) acc = acc - f[i];
      return acc;
   endfunction

   function automatic void push_reply(input frame_type f);
      f[8] = sum_check(f);
      for (int i = 0; i < FRAME_LEN; i++) begin
         expected_tx.push_back('{data: f[i], last: (i == FRAME_LEN - 1)});
      end
   endfunction

   // reply bytes 2..7, byte 2 most significant
   function automatic void set_payload(input logic [47:0] v);
      {held[2], held[3], held[4], held[5], held[6], held[7]} = v;
   endfunction

   function automatic void execute_command(input logic [15:0] adc, input logic [15:0] ppb);
      logic [7:0] code;
      code    = held[2];
      held[1] = code;
      if (code == CMD_SET_SERIAL) serial_reg = {held[3], held[4], held[5], held[6], held[7]};
      case (code)
         CMD_SET_SERIAL, CMD_GET_SERIAL: set_payload({serial_reg, 8'h00});
         CMD_GET_CAL_PPB: set_payload({zero_ppb_reg, span_ppb_reg, 16'h0000});
         CMD_GET_CAL_RAW: set_payload({zero_raw_reg, span_raw_reg, 16'h0000});
         CMD_SET_ZERO: begin
            zero_ppb_reg = {held[3], held[4]};
            zero_raw_reg = {held[5], held[6]};
            set_payload({zero_ppb_reg, zero_raw_reg, 16'h0000});
         end
         CMD_SET_SPAN: begin
            span_ppb_reg = {held[3], held[4]};
            span_raw_reg = {held[5], held[6]};
            set_payload({span_ppb_reg, span_raw_reg, 16'h0000});
         end
         CMD_SET_MODE_A, CMD_SET_MODE_B: begin
            mode_reg = held[3];
            set_payload({mode_reg, 40'h0});
         end
         CMD_READ_ALL: set_payload({adc, 16'h0000, ppb});
         CMD_READ_RAW: set_payload({adc, 32'h0});
         default: ; // echo codes return bytes 3..7 as received
      endcase
      push_reply(held);
   endfunction

   function automatic void predict_request(input logic kind, input logic [7:0] b,
                                           input logic [15:0] adc, input logic [15:0] ppb);
      frame_type up;
      int n;
      n = held_count;
      // upload tick leaves assembly alone
      if (kind == REQ_TICK) begin
         if (mode_reg == MODE_UPLOAD) begin
            up = '0;
            up[0] = SYNC_BYTE;
            up[1] = UPLOAD_CODE;
            up[2] = UPLOAD_B2;
            up[4] = ppb[15:8];
            up[5] = ppb[7:0];
            up[6] = UPLOAD_B6;
            up[7] = UPLOAD_B7;
            push_reply(up);
         end
         return;
      end
      if (n == 0) begin
         if (b == SYNC_BYTE) begin
            held[0] = b;
            n = 1;
         end
      end else if (n == 1) begin
         if (b == ADDR_BYTE) begin
            held[1] = b;
            n = 2;
         end else begin
            n = 0;
         end
      end else if (n == 2) begin
         if (code_is_known(b)) begin
            held[2] = b;
            n = 3;
         end else begin
            n = 0;
         end
      end else if (held[n-2] == SYNC_BYTE && held[n-1] == ADDR_BYTE && code_is_known(b)) begin
         // header seen again: restart with this code
         held[2] = b;
         n = 3;
      end else begin
         held[n] = b;
         n++;
         if (n == FRAME_LEN) begin
            if (sum_check(held) == held[8]) begin
               n = 0;
               execute_command(adc, ppb);
            end else if (held[8] == SYNC_BYTE) begin
               held[0] = SYNC_BYTE;
               n = 1;
            end else if (held[7] == SYNC_BYTE && held[8] == ADDR_BYTE) begin
               held[0] = SYNC_BYTE;
               held[1] = ADDR_BYTE;
               n = 2;
            end else begin
               n = 0;
            end
         end
      end
      held_count = CNT_W'(n);
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   function automatic int draw_gap(input bit no_idle);
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   // valid stays high between back-to-back beats; lowered only for a gap
   task automatic send_request(input logic kind, input logic [7:0] b,
                               input logic [15:0] adc, input logic [15:0] ppb);
      int gap;
      gap = draw_gap(req_no_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.rx_byte    <= b;
      req_bus.adc_sample <= adc;
      req_bus.ppb_value  <= ppb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_request(kind, b, adc, ppb);
      items_sent++;
      if (kind == REQ_TICK) ticks_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(REQ_RX_BYTE, b, 16'($urandom), 16'($urandom));
   endtask

   function automatic frame_type make_frame(input logic [7:0] code, input logic [39:0] d);
      frame_type f;
      f    = '0;
      f[0] = SYNC_BYTE;
      f[1] = ADDR_BYTE;
      f[2] = code;
      {f[3], f[4], f[5], f[6], f[7]} = d;
      f[8] = sum_check(f);
      return f;
   endfunction

   task automatic send_bytes(input frame_type f, input int first, input int stop,
                             input logic [15:0] adc, input logic [15:0] ppb);
      for (int i = first; i <= stop; i++) send_request(REQ_RX_BYTE, f[i], adc, ppb);
   endtask

   task automatic send_command(input logic [7:0] code, input logic [39:0] d,
                               input logic [15:0] adc, input logic [15:0] ppb);
      send_bytes(make_frame(code, d), 0, FRAME_LEN - 1, adc, ppb);
   endtask

   // hold off until every predicted beat is back, then let the pipe settle
   task automatic wait_for_replies();
      req_bus.valid <= 1'b0;
      while (expected_tx.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls and beat checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_tx.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got tx_byte %h frame_last %b",
                        $time, rsp_bus.tx_byte, rsp_bus.frame_last);
               fail_count++;
            end else begin
               want = expected_tx.pop_front();
               if (rsp_bus.tx_byte !== want.data) begin
                  $display("%0t: tx_byte mismatch, expected %h, got %h",
                           $time, want.data, rsp_bus.tx_byte);
                  fail_count++;
               end
               if (rsp_bus.frame_last !== want.last) begin
                  $display("%0t: frame_last mismatch, expected %b, got %b",
                           $time, want.last, rsp_bus.frame_last);
                  fail_count++;
               end
               if (want.last) frames_seen++;
            end
            rsp_hold = draw_gap(rsp_no_idle);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_bus.ready <= (rsp_hold == 0);
      end
   end

   // Watchdog: too long with no beat moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat moved for %0d cycles, %0d beats still expected",
               $time, STALL_LIMIT, expected_tx.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_header_search();
      send_byte(8'h00);
      send_byte(ADDR_BYTE);
      send_byte(SYNC_BYTE);
      send_byte(SYNC_BYTE);   // FF where 01 belongs drops the header
      send_byte(SYNC_BYTE);
      send_byte(8'h02);
      send_byte(SYNC_BYTE);
      send_byte(ADDR_BYTE);
      send_byte(8'h33);       // not a command code
      send_byte(SYNC_BYTE);
      send_byte(ADDR_BYTE);
      send_byte(8'hFF);
      // mode still zero: tick gives nothing
      send_request(REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
      wait_for_replies();
   endtask

   task automatic test_all_commands();
      // back-to-back first so the reply queue backs up
      req_no_idle = 1'b1;
      send_command(CMD_SET_SERIAL, 40'hFF_FFFF_FFFF, 16'h0000, 16'h0000);
      send_command(CMD_GET_SERIAL, 40'h00_0000_0000, 16'hFFFF, 16'hFFFF);
      send_command(CMD_SET_SERIAL, 40'h01_2345_6789, 16'h0000, 16'hFFFF);
      send_command(CMD_GET_SERIAL, 40'hFF_FFFF_FFFF, 16'hFFFF, 16'h0000);
      req_no_idle = 1'b0;
      send_command(CMD_SET_ZERO, 40'hFFFF_0000_00, 16'h1234, 16'h5678);
      send_command(CMD_SET_SPAN, 40'h0000_FFFF_FF, 16'h1234, 16'h5678);
      send_command(CMD_GET_CAL_PPB, 40'h0, 16'h0000, 16'h0000);
      send_command(CMD_GET_CAL_RAW, 40'hFF_FFFF_FFFF, 16'h0000, 16'h0000);
      send_command(CMD_ECHO_A, 40'hFF_FFFF_FFFF, 16'h0000, 16'h0000);
      send_command(CMD_ECHO_B, 40'h00_0000_0000, 16'hFFFF, 16'hFFFF);
      send_command(CMD_SET_MODE_B, 40'h7F_0000_0000, 16'h0000, 16'h0000);
      send_command(CMD_SET_MODE_A, {MODE_UPLOAD, 32'hFFFF_FFFF}, 16'h0000, 16'h0000);
      send_command(CMD_READ_ALL, 40'h0, 16'hFFFF, 16'h0000);
      send_command(CMD_READ_ALL, 40'h0, 16'h0000, 16'hFFFF);
      send_command(CMD_READ_RAW, 40'hFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_command(CMD_READ_RAW, 40'h0, 16'h0000, 16'h0000);
      wait_for_replies();
   endtask

   task automatic test_header_restart();
      frame_type f;
      // partial frame cut off by a fresh FF 01 code
      send_byte(SYNC_BYTE);
      send_byte(ADDR_BYTE);
      send_byte(CMD_SET_SERIAL);
      send_byte(8'hAA);
      send_command(CMD_GET_SERIAL, 40'h0, 16'h0000, 16'h0000);
      // FF 01 inside the data but followed by a non-code stays in the frame
      send_command(CMD_ECHO_A, {SYNC_BYTE, ADDR_BYTE, 24'h00_1234}, 16'h0000, 16'h0000);
      // FF 01 in the last data bytes, code arrives in the check slot
      f = make_frame(CMD_ECHO_B, {24'h0, SYNC_BYTE, ADDR_BYTE});
      send_bytes(f, 0, 7, 16'h0000, 16'h0000);
      send_bytes(make_frame(CMD_GET_CAL_RAW, 40'h0), 2, 8, 16'h0000, 16'h0000);
      wait_for_replies();
   endtask

   task automatic test_bad_checksum();
      frame_type f;
      // bad check equal to FF: resume holding FF
      f    = make_frame(CMD_GET_CAL_PPB, 40'h0);
      f[8] = SYNC_BYTE;
      send_bytes(f, 0, 8, 16'h0000, 16'h0000);
      send_bytes(make_frame(CMD_GET_SERIAL, 40'h0), 1, 8, 16'h0000, 16'h0000);
      // bad check with FF 01 tail: resume holding FF 01
      f    = make_frame(CMD_GET_CAL_RAW, 40'h00_0000_00FF);
      f[8] = ADDR_BYTE;
      send_bytes(f, 0, 8, 16'h0000, 16'h0000);
      send_bytes(make_frame(CMD_READ_RAW, 40'h0), 2, 8, 16'hA5A5, 16'h5A5A);
      // plain bad check: back to header search
      f    = make_frame(CMD_ECHO_A, 40'h0);
      f[8] = 8'h00;
      send_bytes(f, 0, 8, 16'h0000, 16'h0000);
      send_command(CMD_ECHO_B, 40'h0, 16'h0000, 16'h0000);
      wait_for_replies();
   endtask

   task automatic test_upload_ticks();
      frame_type f;
      send_command(CMD_SET_MODE_A, {MODE_UPLOAD, 32'h0}, 16'h0000, 16'h0000);
      send_request(REQ_TICK, 8'hFF, 16'h0000, 16'hFFFF);
      send_request(REQ_TICK, 8'h00, 16'hFFFF, 16'h0000);
      // tick in the middle of a frame leaves assembly intact
      f = make_frame(CMD_READ_ALL, 40'h0);
      send_bytes(f, 0, 3, 16'h0000, 16'h0000);
      send_request(REQ_TICK, 8'h5A, 16'h0F0F, 16'hF0F0);
      send_bytes(f, 4, 8, 16'h1234, 16'h5678);
      // any other mode: ticks are silent
      send_command(CMD_SET_MODE_B, {8'h41, 32'h0}, 16'h0000, 16'h0000);
      send_request(REQ_TICK, 8'h00, 16'hFFFF, 16'hFFFF);
      wait_for_replies();
   endtask

   // random traffic tops the run up to the target item count
   task automatic test_random_traffic();
      frame_type   f;
      logic [39:0] d;
      int          first;
      int          cut;
      bit          paused;
      first   = items_sent;
      paused  = 1'b0;
      while (items_sent < TOTAL_ITEMS) begin
         // switch between idling and back-to-back stretches
         if ($urandom_range(0, 11) == 0) begin
            req_no_idle = ($urandom_range(0, 2) == 0);
            rsp_no_idle = ($urandom_range(0, 2) == 0);
         end
         if (!paused && (items_sent - first) >= (TOTAL_ITEMS - first) / 2) begin
            wait_for_replies();
            paused = 1'b1;
         end
         case ($urandom_range(0, 3))
            0:       d = '0;
            1:       d = '1;
            default: d = {8'($urandom), 32'($urandom)};
         endcase
         f = make_frame(command_codes[$urandom_range(0, 11)], d);
         if ((f[2] == CMD_SET_MODE_A || f[2] == CMD_SET_MODE_B) && $urandom_range(0, 1) == 1) begin
            f[3] = MODE_UPLOAD;
            f[8] = sum_check(f);
         end
         case ($urandom_range(0, 19))
            0, 1: begin
               // line noise
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            2, 3: begin
               send_request(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
            end
            4, 5, 6: begin
               // broken frame: bad check, resync tails or cut short
               cut = FRAME_LEN - 1;
               case ($urandom_range(0, 3))
                  0: f[8] = f[8] ^ 8'($urandom_range(1, 255));
                  1: f[8] = SYNC_BYTE;
                  2: begin
                     f[7] = SYNC_BYTE;
                     f[8] = ADDR_BYTE;
                  end
                  default: cut = $urandom_range(0, 7);
               endcase
               send_bytes(f, 0, cut, 16'($urandom), 16'($urandom));
            end
            default: begin
               send_bytes(f, 0, FRAME_LEN - 1, 16'($urandom), 16'($urandom));
            end
         endcase
      end
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_RX_BYTE;
      req_bus.rx_byte    <= '0;
      req_bus.adc_sample <= '0;
      req_bus.ppb_value  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_header_search();
      test_all_commands();
      test_header_restart();
      test_bad_checksum();
      test_upload_ticks();
      test_random_traffic();
      wait_for_replies();

      $display("Sent %0d request beats (%0d upload ticks), checked %0d reply frames:",
               items_sent, ticks_sent, frames_seen);
      $display("header search and restart, bad checks, all command codes, upload mode.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/scfh_pkg.sv
sv/scfh_if.sv
sv/scfh_parser.sv
sv/scfh_tx.sv
sv/sensor_command_frame_handler.sv
verif/tb_sensor_command_frame_handler.sv
